/* src/bot_pkg.sv */
package bot_pkg;

   localparam int MAX_LUNS_DEFAULT = 4;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_CBW   = 2'd1;
   localparam logic [1:0] FUNC_DATA  = 2'd2;
   localparam logic [1:0] FUNC_CSW   = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CBW  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_CSW  = 2'd3;

   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_CBW   = 3'd1;
   localparam logic [2:0] ACT_DATA  = 3'd2;
   localparam logic [2:0] ACT_CSW   = 3'd3;
   localparam logic [2:0] ACT_RESET = 3'd4;
   localparam logic [2:0] ACT_DONE  = 3'd5;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_INVAL = 3'd1;
   localparam logic [2:0] ST_FAIL  = 3'd2;
   localparam logic [2:0] ST_XPORT = 3'd3;
   localparam logic [2:0] ST_PHASE = 3'd4;
   localparam logic [2:0] ST_UNEXP = 3'd5;

   localparam logic [7:0] OP_READ10  = 8'h28;
   localparam logic [7:0] OP_WRITE10 = 8'h2A;
   localparam logic [7:0] OP_READ16  = 8'h88;
   localparam logic [7:0] OP_WRITE16 = 8'h8A;
   localparam logic [4:0] CDB_LEN10  = 5'd10;
   localparam logic [4:0] CDB_LEN16  = 5'd16;

   localparam logic [31:0] CSW_SIG   = 32'h5342_5355;
   localparam logic [31:0] CBW_BYTES = 32'd31;
   localparam logic [31:0] CSW_BYTES = 32'd13;
   localparam logic [7:0]  CSW_PASSED = 8'd0;
   localparam logic [7:0]  CSW_FAILED = 8'd1;

   localparam logic [1:0] CSR_NUM_LUNS = 2'd0;
   localparam logic [1:0] CSR_BLK_LOG2 = 2'd1;
   localparam logic [2:0] NUM_LUNS_RESET = 3'd1;
   localparam logic [4:0] BLK_LOG2_RESET = 5'd9;

   typedef struct packed {
      logic [2:0] num_luns;
      logic [4:0] block_size_log2;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  lun;
      logic [63:0] lba;
      logic [31:0] block_count;
      logic        write;
      logic        phase_ok;
      logic [31:0] actual_bytes;
      logic [31:0] csw_signature;
      logic [31:0] csw_tag;
      logic [31:0] csw_residue;
      logic [7:0]  csw_status;
   } item_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] tag_counter;
      logic [31:0] saved_length;
      logic [31:0] saved_actual;
      logic        saved_direction;
   } state_type;

   typedef struct packed {
      logic [2:0]  next_action;
      logic [2:0]  result_status;
      logic [31:0] cbw_tag;
      logic [31:0] transfer_length;
      logic        direction_in;
      logic [7:0]  cdb_opcode;
      logic [4:0]  cdb_length;
      logic [31:0] actual_data;
   } result_type;

endpackage

/* src/bot_block_command_sequencer_top.sv */
// A request loads the item register, and its result loads the result register
// when rsp_stall allows. Throughput: one transaction per cycle unless stalled;
// sequencer state registers update in the same cycle the result register loads.
// Reset: synchronous, active high; clears handshake state, phase, tag and saved
// values, and sets num_luns to 1 and block_size_log2 to 9.
module bot_block_command_sequencer_top #(
   parameter int MAX_LUNS = bot_pkg::MAX_LUNS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_lun,
   input  logic [63:0] req_lba,
   input  logic [31:0] req_block_count,
   input  logic        req_write,
   input  logic        req_phase_ok,
   input  logic [31:0] req_actual_bytes,
   input  logic [31:0] req_csw_signature,
   input  logic [31:0] req_csw_tag,
   input  logic [31:0] req_csw_residue,
   input  logic [7:0]  req_csw_status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_next_action,
   output logic [2:0]  rsp_result_status,
   output logic [31:0] rsp_cbw_tag,
   output logic [31:0] rsp_transfer_length,
   output logic        rsp_direction_in,
   output logic [7:0]  rsp_cdb_opcode,
   output logic [4:0]  rsp_cdb_length,
   output logic [31:0] rsp_actual_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import bot_pkg::*;

   cfg_type    cfg_ff;
   item_type   item_ff, item_in;
   logic       item_vld_ff;
   state_type  state_ff, state_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_vld_ff;
   logic       advance;
   logic       req_take;

   assign csr_ready = 1'b1;
   assign advance   = item_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = item_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign item_in.func          = req_func;
   assign item_in.lun           = req_lun;
   assign item_in.lba           = req_lba;
   assign item_in.block_count   = req_block_count;
   assign item_in.write         = req_write;
   assign item_in.phase_ok      = req_phase_ok;
   assign item_in.actual_bytes  = req_actual_bytes;
   assign item_in.csw_signature = req_csw_signature;
   assign item_in.csw_tag       = req_csw_tag;
   assign item_in.csw_residue   = req_csw_residue;
   assign item_in.csw_status    = req_csw_status;

   bot_step #(
      .MAX_LUNS (MAX_LUNS)
   ) u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_luns        <= NUM_LUNS_RESET;
         cfg_ff.block_size_log2 <= BLK_LOG2_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NUM_LUNS) begin
            cfg_ff.num_luns <= csr_wdata[2:0];
         end else if (csr_index == CSR_BLK_LOG2) begin
            cfg_ff.block_size_log2 <= csr_wdata[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         state_ff    <= '0;
      end else begin
         if (req_take) begin
            item_vld_ff <= 1'b1;
         end else if (advance) begin
            item_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_next_action     = rsp_ff.next_action;
   assign rsp_result_status   = rsp_ff.result_status;
   assign rsp_cbw_tag         = rsp_ff.cbw_tag;
   assign rsp_transfer_length = rsp_ff.transfer_length;
   assign rsp_direction_in    = rsp_ff.direction_in;
   assign rsp_cdb_opcode      = rsp_ff.cdb_opcode;
   assign rsp_cdb_length      = rsp_ff.cdb_length;
   assign rsp_actual_data     = rsp_ff.actual_data;

endmodule

/* src/bot_step.sv */
module bot_step #(
   parameter int MAX_LUNS = bot_pkg::MAX_LUNS_DEFAULT
) (
   input  bot_pkg::cfg_type    cfg,
   input  bot_pkg::state_type  state_cur,
   input  bot_pkg::item_type   item,
   output bot_pkg::state_type  state_nxt,
   output bot_pkg::result_type result
);
   import bot_pkg::*;

   localparam logic [7:0] MaxLuns = 8'(MAX_LUNS);

   logic [7:0]  usable;
   logic [31:0] tag_inc;
   logic [31:0] room;
   logic        short_cdb;
   logic [2:0]  act;
   logic [2:0]  stat;
   logic [7:0]  opcode;
   logic [4:0]  clen;
   logic [31:0] actual_clamped;

   assign usable    = (8'(cfg.num_luns) < MaxLuns) ? 8'(cfg.num_luns) : MaxLuns;
   assign tag_inc   = state_cur.tag_counter + 32'd1;
   assign room      = state_cur.saved_length - item.csw_residue;
   assign short_cdb = (item.lba[63:32] == 32'd0) && (item.block_count[31:16] == 16'd0);
   assign actual_clamped =
      (state_cur.saved_length != 32'd0 && state_cur.saved_actual > room) ?
      room : state_cur.saved_actual;

   always_comb begin
      state_nxt = state_cur;
      act       = ACT_NONE;
      stat      = ST_UNEXP;
      opcode    = 8'd0;
      clen      = 5'd0;
      case (item.func)
         FUNC_START: begin
            if (state_cur.phase == PH_IDLE) begin
               if (item.lun >= usable) begin
                  stat = ST_INVAL;
               end else begin
                  state_nxt.tag_counter     = (tag_inc == 32'd0) ? 32'd1 : tag_inc;
                  state_nxt.saved_length    = item.block_count << cfg.block_size_log2;
                  state_nxt.saved_direction = ~item.write;
                  state_nxt.saved_actual    = 32'd0;
                  state_nxt.phase           = PH_CBW;
                  act  = ACT_CBW;
                  stat = ST_OK;
                  if (short_cdb) begin
                     opcode = item.write ? OP_WRITE10 : OP_READ10;
                     clen   = CDB_LEN10;
                  end else begin
                     opcode = item.write ? OP_WRITE16 : OP_READ16;
                     clen   = CDB_LEN16;
                  end
               end
            end
         end
         FUNC_CBW: begin
            if (state_cur.phase == PH_CBW) begin
               if (!item.phase_ok || item.actual_bytes != CBW_BYTES) begin
                  state_nxt.phase = PH_IDLE;
                  act  = ACT_RESET;
                  stat = ST_XPORT;
               end else if (state_cur.saved_length != 32'd0) begin
                  state_nxt.phase = PH_DATA;
                  act  = ACT_DATA;
                  stat = ST_OK;
               end else begin
                  state_nxt.saved_actual = 32'd0;
                  state_nxt.phase        = PH_CSW;
                  act  = ACT_CSW;
                  stat = ST_OK;
               end
            end
         end
         FUNC_DATA: begin
            if (state_cur.phase == PH_DATA) begin
               if (!item.phase_ok) begin
                  state_nxt.phase = PH_IDLE;
                  act  = ACT_RESET;
                  stat = ST_XPORT;
               end else begin
                  state_nxt.saved_actual = item.actual_bytes;
                  state_nxt.phase        = PH_CSW;
                  act  = ACT_CSW;
                  stat = ST_OK;
               end
            end
         end
         FUNC_CSW: begin
            if (state_cur.phase == PH_CSW) begin
               state_nxt.phase = PH_IDLE;
               if (!item.phase_ok || item.actual_bytes != CSW_BYTES) begin
                  act  = ACT_RESET;
                  stat = ST_XPORT;
               end else if (item.csw_signature != CSW_SIG ||
                            item.csw_tag != state_cur.tag_counter ||
                            item.csw_residue > state_cur.saved_length) begin
                  act  = ACT_RESET;
                  stat = ST_PHASE;
               end else begin
                  state_nxt.saved_actual = actual_clamped;
                  if (item.csw_status == CSW_PASSED) begin
                     act  = ACT_DONE;
                     stat = (actual_clamped == state_cur.saved_length) ? ST_OK : ST_FAIL;
                  end else if (item.csw_status == CSW_FAILED) begin
                     act  = ACT_DONE;
                     stat = ST_FAIL;
                  end else begin
                     act  = ACT_RESET;
                     stat = ST_PHASE;
                  end
               end
            end
         end
         default: begin
            act = ACT_NONE;
         end
      endcase
   end

   assign result.next_action     = act;
   assign result.result_status   = stat;
   assign result.cbw_tag         = state_nxt.tag_counter;
   assign result.transfer_length = state_nxt.saved_length;
   assign result.direction_in    = state_nxt.saved_direction;
   assign result.cdb_opcode      = opcode;
   assign result.cdb_length      = clen;
   assign result.actual_data     = state_nxt.saved_actual;

endmodule

/* src/bot_checker.sv */
module bot_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_next_action,
   input logic [2:0]  rsp_result_status,
   input logic [31:0] rsp_cbw_tag,
   input logic [31:0] rsp_transfer_length,
   input logic [7:0]  rsp_cdb_opcode,
   input logic [4:0]  rsp_cdb_length,
   input logic [31:0] rsp_actual_data
);
   import bot_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_action) &&
      $stable(rsp_result_status) && $stable(rsp_cbw_tag) && $stable(rsp_actual_data))
      else $error("stalled result changed");

   a_start_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_action == ACT_CBW |->
      rsp_cbw_tag != 32'd0 && rsp_result_status == ST_OK &&
      (rsp_cdb_length == CDB_LEN10 || rsp_cdb_length == CDB_LEN16))
      else $error("bad command start result");

   a_cdb_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_action != ACT_CBW |->
      rsp_cdb_opcode == 8'd0 && rsp_cdb_length == 5'd0)
      else $error("command block fields outside a start");

   a_done_ok_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_action == ACT_DONE && rsp_result_status == ST_OK |->
      rsp_actual_data == rsp_transfer_length)
      else $error("completed ok with short data");

endmodule

bind bot_block_command_sequencer_top bot_checker u_bot_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_next_action     (rsp_next_action),
   .rsp_result_status   (rsp_result_status),
   .rsp_cbw_tag         (rsp_cbw_tag),
   .rsp_transfer_length (rsp_transfer_length),
   .rsp_cdb_opcode      (rsp_cdb_opcode),
   .rsp_cdb_length      (rsp_cdb_length),
   .rsp_actual_data     (rsp_actual_data)
);

/* bench/tb_bot_block_command_sequencer_top.sv */
`timescale 1ns / 1ps

module tb_bot_block_command_sequencer_top;
   import bot_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;

   class bot_command_tracker;
      logic [2:0]  luns;
      logic [4:0]  blk_shift;
      logic [1:0]  ph;
      logic [31:0] tag;
      logic [31:0] xfer_len;
      logic [31:0] xfer_actual;
      logic        dir_in;
      result_type  answers_due[$];
      int          errors;

      function new();
         luns = NUM_LUNS_RESET;
         blk_shift = BLK_LOG2_RESET;
         ph = PH_IDLE;
         tag = '0;
         xfer_len = '0;
         xfer_actual = '0;
         dir_in = 1'b0;
         errors = 0;
      endfunction

      function int usable_luns();
         return (luns < MAX_LUNS_DEFAULT) ? int'(luns) : MAX_LUNS_DEFAULT;
      endfunction

      function int outstanding();
         return answers_due.size();
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] val);
         if (idx == CSR_NUM_LUNS) luns = val[2:0];
         else if (idx == CSR_BLK_LOG2) blk_shift = val[4:0];
      endfunction

      function void note_request(item_type it);
         logic [2:0] act;
         logic [2:0] st;
         logic [7:0] op;
         logic [4:0] clen;
         result_type r;
         act = ACT_NONE;
         st = ST_UNEXP;
         op = '0;
         clen = '0;
         case (it.func)
            FUNC_START: begin
               if (ph == PH_IDLE) begin
                  if (int'(it.lun) >= usable_luns()) begin
                     st = ST_INVAL;
                  end else begin
                     tag = tag + 1;
                     if (tag == 0) tag = 1;
                     xfer_len = it.block_count << blk_shift;
                     dir_in = !it.write;
                     xfer_actual = '0;
                     if (it.lba <= 64'hffff_ffff && it.block_count <= 32'hffff) begin
                        op = it.write ? OP_WRITE10 : OP_READ10;
                        clen = CDB_LEN10;
                     end else begin
                        op = it.write ? OP_WRITE16 : OP_READ16;
                        clen = CDB_LEN16;
                     end
                     ph = PH_CBW;
                     act = ACT_CBW;
                     st = ST_OK;
                  end
               end
            end
            FUNC_CBW: begin
               if (ph == PH_CBW) begin
                  if (!it.phase_ok || it.actual_bytes != CBW_BYTES) begin
                     ph = PH_IDLE;
                     act = ACT_RESET;
                     st = ST_XPORT;
                  end else if (xfer_len != 0) begin
                     ph = PH_DATA;
                     act = ACT_DATA;
                     st = ST_OK;
                  end else begin
                     xfer_actual = '0;
                     ph = PH_CSW;
                     act = ACT_CSW;
                     st = ST_OK;
                  end
               end
            end
            FUNC_DATA: begin
               if (ph == PH_DATA) begin
                  if (!it.phase_ok) begin
                     ph = PH_IDLE;
                     act = ACT_RESET;
                     st = ST_XPORT;
                  end else begin
                     xfer_actual = it.actual_bytes;
                     ph = PH_CSW;
                     act = ACT_CSW;
                     st = ST_OK;
                  end
               end
            end
            default: begin
               if (ph == PH_CSW) begin
                  ph = PH_IDLE;
                  act = ACT_RESET;
                  if (!it.phase_ok || it.actual_bytes != CSW_BYTES) begin
                     st = ST_XPORT;
                  end else if (it.csw_signature != CSW_SIG || it.csw_tag != tag ||
                               it.csw_residue > xfer_len) begin
                     st = ST_PHASE;
                  end else begin
                     if (xfer_len != 0 && xfer_actual > xfer_len - it.csw_residue)
                        xfer_actual = xfer_len - it.csw_residue;
                     if (it.csw_status == CSW_PASSED) begin
                        act = ACT_DONE;
                        st = (xfer_actual == xfer_len) ? ST_OK : ST_FAIL;
                     end else if (it.csw_status == CSW_FAILED) begin
                        act = ACT_DONE;
                        st = ST_FAIL;
                     end else begin
                        st = ST_PHASE;
                     end
                  end
               end
            end
         endcase
         r.next_action = act;
         r.result_status = st;
         r.cbw_tag = tag;
         r.transfer_length = xfer_len;
         r.direction_in = dir_in;
         r.cdb_opcode = op;
         r.cdb_length = clen;
         r.actual_data = xfer_actual;
         answers_due.push_back(r);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_answer(result_type got);
         result_type want;
         if (answers_due.size() == 0) begin
            $error("result transaction with nothing outstanding");
            errors++;
            return;
         end
         want = answers_due.pop_front();
         check_field("next_action", 32'(want.next_action), 32'(got.next_action));
         check_field("result_status", 32'(want.result_status), 32'(got.result_status));
         check_field("cbw_tag", want.cbw_tag, got.cbw_tag);
         check_field("transfer_length", want.transfer_length, got.transfer_length);
         check_field("direction_in", 32'(want.direction_in), 32'(got.direction_in));
         check_field("cdb_opcode", 32'(want.cdb_opcode), 32'(got.cdb_opcode));
         check_field("cdb_length", 32'(want.cdb_length), 32'(got.cdb_length));
         check_field("actual_data", want.actual_data, got.actual_data);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   item_type   req_item = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_next_action;
   logic [2:0] rsp_result_status;
   logic [31:0] rsp_cbw_tag;
   logic [31:0] rsp_transfer_length;
   logic       rsp_direction_in;
   logic [7:0] rsp_cdb_opcode;
   logic [4:0] rsp_cdb_length;
   logic [31:0] rsp_actual_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   result_type rsp_seen;
   bot_command_tracker sb;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int items_sent = 0;

   assign rsp_seen = {rsp_next_action, rsp_result_status, rsp_cbw_tag, rsp_transfer_length,
                      rsp_direction_in, rsp_cdb_opcode, rsp_cdb_length, rsp_actual_data};

   bot_block_command_sequencer_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_item.func),
      .req_lun             (req_item.lun),
      .req_lba             (req_item.lba),
      .req_block_count     (req_item.block_count),
      .req_write           (req_item.write),
      .req_phase_ok        (req_item.phase_ok),
      .req_actual_bytes    (req_item.actual_bytes),
      .req_csw_signature   (req_item.csw_signature),
      .req_csw_tag         (req_item.csw_tag),
      .req_csw_residue     (req_item.csw_residue),
      .req_csw_status      (req_item.csw_status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_next_action     (rsp_next_action),
      .rsp_result_status   (rsp_result_status),
      .rsp_cbw_tag         (rsp_cbw_tag),
      .rsp_transfer_length (rsp_transfer_length),
      .rsp_direction_in    (rsp_direction_in),
      .rsp_cdb_opcode      (rsp_cdb_opcode),
      .rsp_cdb_length      (rsp_cdb_length),
      .rsp_actual_data     (rsp_actual_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_answer(rsp_seen);
   end

   // result side: random stall, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (80) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = !quiet && ($urandom_range(0, 99) < 22);
         end
      end
   end

   initial begin
      #4000000;
      $display("bot_block_command_sequencer_top: mismatch");
      $finish;
   end

   task automatic offer(input item_type it);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < 22) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_item = it;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(it);
      items_sent++;
   endtask

   task automatic park();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      park();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic item_type noise_item();
      item_type it;
      it.func = 2'($urandom_range(0, 3));
      it.lun = 8'($urandom);
      it.lba = {$urandom, $urandom};
      it.block_count = $urandom;
      it.write = 1'($urandom);
      it.phase_ok = 1'($urandom);
      it.actual_bytes = $urandom;
      it.csw_signature = $urandom;
      it.csw_tag = $urandom;
      it.csw_residue = $urandom;
      it.csw_status = 8'($urandom);
      return it;
   endfunction

   function automatic item_type start_cmd(logic [7:0] lun, logic [63:0] lba,
                                          logic [31:0] cnt, logic wr);
      item_type it;
      it = '0;
      it.func = FUNC_START;
      it.lun = lun;
      it.lba = lba;
      it.block_count = cnt;
      it.write = wr;
      return it;
   endfunction

   function automatic item_type bulk_report(logic [1:0] f, logic ok, logic [31:0] nbytes);
      item_type it;
      it = '0;
      it.func = f;
      it.phase_ok = ok;
      it.actual_bytes = nbytes;
      return it;
   endfunction

   function automatic item_type csw_report(logic [31:0] sig, logic [31:0] ctag,
                                           logic [31:0] res, logic [7:0] status);
      item_type it;
      it = bulk_report(FUNC_CSW, 1'b1, CSW_BYTES);
      it.csw_signature = sig;
      it.csw_tag = ctag;
      it.csw_residue = res;
      it.csw_status = status;
      return it;
   endfunction

   function automatic item_type random_start();
      item_type it;
      int n;
      it = noise_item();
      it.func = FUNC_START;
      n = sb.usable_luns();
      if (n > 0 && $urandom_range(0, 99) < 90) it.lun = 8'($urandom_range(0, n - 1));
      case ($urandom_range(0, 3))
         0: it.lba = {32'd0, $urandom};
         1: it.lba = {$urandom, $urandom};
         2: it.lba = 64'hffff_ffff;
         default: it.lba = 64'h1_0000_0000;
      endcase
      case ($urandom_range(0, 7))
         0: it.block_count = '0;
         1: it.block_count = 32'hffff;
         2: it.block_count = 32'h1_0000;
         3: it.block_count = $urandom;
         default: it.block_count = $urandom_range(1, 8);
      endcase
      return it;
   endfunction

   function automatic item_type random_report();
      item_type it;
      logic [31:0] len;
      it = noise_item();
      len = sb.xfer_len;
      case (sb.ph)
         PH_CBW: begin
            it.func = FUNC_CBW;
            it.phase_ok = $urandom_range(0, 99) < 92;
            if ($urandom_range(0, 99) < 92) it.actual_bytes = CBW_BYTES;
            else if ($urandom_range(0, 1)) it.actual_bytes = $urandom_range(0, 40);
         end
         PH_DATA: begin
            it.func = FUNC_DATA;
            it.phase_ok = $urandom_range(0, 99) < 94;
            case ($urandom_range(0, 3))
               0: it.actual_bytes = len;
               1: it.actual_bytes = $urandom_range(0, len);
               2: it.actual_bytes = len + $urandom_range(1, 100);
               default: it.actual_bytes = $urandom;
            endcase
         end
         default: begin
            it.func = FUNC_CSW;
            it.phase_ok = $urandom_range(0, 99) < 94;
            it.actual_bytes = ($urandom_range(0, 99) < 94) ? CSW_BYTES : $urandom_range(0, 20);
            if ($urandom_range(0, 99) < 94) it.csw_signature = CSW_SIG;
            if ($urandom_range(0, 99) < 94) it.csw_tag = sb.tag;
            case ($urandom_range(0, 4))
               0: it.csw_residue = '0;
               1: it.csw_residue = $urandom_range(0, len);
               2: it.csw_residue = (sb.xfer_actual <= len) ? len - sb.xfer_actual : '0;
               3: it.csw_residue = len + 1;
               default: it.csw_residue = '0;
            endcase
            if ($urandom_range(0, 99) < 70) it.csw_status = CSW_PASSED;
            else if ($urandom_range(0, 99) < 60) it.csw_status = CSW_FAILED;
         end
      endcase
      if ($urandom_range(0, 99) < 5) it.func = 2'($urandom_range(0, 3));
      return it;
   endfunction

   task automatic run_command();
      int guard;
      guard = 0;
      offer(random_start());
      while (sb.ph != PH_IDLE && guard < 8) begin
         offer(random_report());
         guard++;
      end
   endtask

   initial begin
      logic [2:0] lun_set[6];
      logic [4:0] shift_set[6];
      int target;
      sb = new();
      lun_set = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd2, 3'd3};
      shift_set = '{5'd16, 5'd9, 5'd31, 5'd0, 5'd12, 5'd9};
      shift_set[5] = 5'($urandom_range(9, 16));
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(CSR_NUM_LUNS, {5'($urandom), 3'd4});
      write_reg(CSR_BLK_LOG2, {3'($urandom), 5'd16});
      offer(bulk_report(FUNC_CBW, 1'b1, CBW_BYTES));
      offer(start_cmd(8'd4, '0, '0, 1'b0));
      offer(start_cmd(8'hff, '0, '0, 1'b0));
      offer(start_cmd(8'd0, '0, '0, 1'b0));
      offer(csw_report(CSW_SIG, sb.tag, '0, CSW_PASSED));
      offer(bulk_report(FUNC_CBW, 1'b1, CBW_BYTES));
      offer(start_cmd(8'd1, '0, 32'd1, 1'b1));
      offer(bulk_report(FUNC_DATA, 1'b1, 32'd5));
      offer(csw_report(CSW_SIG, sb.tag, '0, CSW_PASSED));
      offer(start_cmd(8'd3, '1, '1, 1'b1));
      offer(bulk_report(FUNC_CBW, 1'b0, CBW_BYTES));
      offer(start_cmd(8'd1, 64'hffff_ffff, 32'hffff, 1'b1));
      offer(bulk_report(FUNC_CBW, 1'b1, 32'd30));
      offer(start_cmd(8'd2, 64'h1_0000_0000, 32'd1, 1'b0));
      offer(bulk_report(FUNC_CBW, 1'b1, CBW_BYTES));
      offer(bulk_report(FUNC_DATA, 1'b0, '0));
      offer(start_cmd(8'd0, '0, 32'h1_0000, 1'b0));
      offer(bulk_report(FUNC_CBW, 1'b1, CBW_BYTES));
      offer(bulk_report(FUNC_DATA, 1'b1, '1));
      offer(csw_report(CSW_SIG, sb.tag, 32'd5, CSW_PASSED));
      offer(start_cmd(8'd0, 64'd5, 32'd2, 1'b1));
      offer(bulk_report(FUNC_CBW, 1'b1, CBW_BYTES));
      offer(bulk_report(FUNC_DATA, 1'b1, sb.xfer_len));
      offer(csw_report(~CSW_SIG, sb.tag, '0, CSW_PASSED));
      offer(start_cmd(8'd3, 64'd9, 32'd3, 1'b0));
      offer(bulk_report(FUNC_CBW, 1'b1, CBW_BYTES));
      offer(bulk_report(FUNC_DATA, 1'b1, sb.xfer_len));
      offer(csw_report(CSW_SIG, sb.tag, '0, CSW_FAILED));

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         write_reg(CSR_NUM_LUNS, {5'($urandom), lun_set[p]});
         write_reg(CSR_BLK_LOG2, {3'($urandom), shift_set[p]});
         if (p == 0) write_reg(CSR_SPARE, 8'($urandom));
         quiet = (p == 2);
         if (p == 1) hold_request = 1'b1;
         target = items_sent + ((lun_set[p] == 0) ? 40 : 130);
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 12) offer(noise_item());
            else run_command();
         end
         quiet = 1'b0;
      end

      park();
      for (int n = 0; n < 2000 && sb.outstanding() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.outstanding() != 0)
         $error("%0d result transactions never arrived", sb.outstanding());
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("bot_block_command_sequencer_top: match");
      end else begin
         $display("bot_block_command_sequencer_top: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/bot_pkg.sv
src/bot_step.sv
src/bot_block_command_sequencer_top.sv
src/bot_checker.sv
bench/tb_bot_block_command_sequencer_top.sv
